// File: rtl/lgsa_pkg.sv
// Shared types and constants for the labeled graph adjacency store.
package lgsa_pkg;

  localparam int MaxVertices = 1024;
  localparam int MaxDegree   = 32;
  localparam int VidW        = 10;
  localparam int PosW        = 5;
  localparam int LenW        = 6;
  localparam int LabelW      = 16;
  localparam int FuncW       = 3;
  localparam int StatusW     = 3;
  localparam int VcountW     = 11;
  localparam int EcountW     = 15;
  localparam int BoundW      = 17;
  localparam int NbAddrW     = VidW + PosW;
  localparam int NbDepth     = MaxVertices * MaxDegree;

  localparam logic [FuncW-1:0] FnAddV = 3'd0;
  localparam logic [FuncW-1:0] FnRemV = 3'd1;
  localparam logic [FuncW-1:0] FnAddE = 3'd2;
  localparam logic [FuncW-1:0] FnRemE = 3'd3;
  localparam logic [FuncW-1:0] FnLook = 3'd4;

  localparam logic [StatusW-1:0] StDone = 3'd0;
  localparam logic [StatusW-1:0] StDup  = 3'd1;
  localparam logic [StatusW-1:0] StMiss = 3'd2;
  localparam logic [StatusW-1:0] StFull = 3'd3;
  localparam logic [StatusW-1:0] StOor  = 3'd4;

  typedef struct packed {
    logic              present;
    logic [LenW-1:0]   len;
    logic [LabelW-1:0] label;
  } vrec_t;

  typedef struct packed {
    logic [VidW-1:0]   id;
    logic [LabelW-1:0] elabel;
  } nrec_t;

  typedef struct packed {
    logic              we;
    logic [VidW-1:0]   waddr;
    vrec_t             wdata;
    logic [VidW-1:0]   raddr;
  } vreq_t;

  typedef struct packed {
    logic               we;
    logic [NbAddrW-1:0] waddr;
    nrec_t              wdata;
    logic [NbAddrW-1:0] raddr;
  } nreq_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [LabelW-1:0]  label_a;
    logic               a_exists;
    logic [LabelW-1:0]  label_b;
    logic               b_exists;
    logic [LabelW-1:0]  edge_label;
    logic               edge_found;
    logic [EcountW-1:0] edge_total;
    logic [VcountW-1:0] vertex_total;
    logic [BoundW-1:0]  vertex_label_bound;
    logic [BoundW-1:0]  edge_label_bound;
  } result_t;

endpackage

// File: rtl/lgsa_ram.sv
// Generic single write, single read RAM with registered read data.
module lgsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/lgsa_ctrl.sv
// Operation sequencer: reads, shifts and writes back vertex records and adjacency lists.
module lgsa_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lgsa_pkg::FuncW-1:0]    in_func,
  input  logic [lgsa_pkg::VidW-1:0]     in_vertex_a,
  input  logic [lgsa_pkg::VidW-1:0]     in_vertex_b,
  input  logic [lgsa_pkg::LabelW-1:0]   in_label,
  output lgsa_pkg::vreq_t               vreq,
  input  lgsa_pkg::vrec_t               vrd,
  output lgsa_pkg::nreq_t               nreq,
  input  lgsa_pkg::nrec_t               nrd,
  output logic                          res_valid,
  input  logic                          res_take,
  output lgsa_pkg::result_t             res
);
  import lgsa_pkg::*;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_RDA, S_RDB, S_EXEC, S_SRCH_RD, S_SRCH_CMP, S_SDONE,
    S_CHK_RD, S_CHK_CMP, S_INS_STEP, S_INS_WR, S_INS_PUT, S_ERS_STEP,
    S_ERS_WR, S_LEN_WR, S_BS_STEP, S_BS_CMP, S_RESP
  } state_t;

  typedef enum logic [1:0] {PH_CHKA, PH_CHKB, PH_MODA, PH_MODB} phase_t;

  state_t              state_r;
  phase_t              ph_r;
  logic [FuncW-1:0]    op_r;
  logic [VidW-1:0]     a_r, b_r, cur_r, key_r;
  logic [LabelW-1:0]   lab_r;
  vrec_t               reca_r, recb_r;
  logic [LenW-1:0]     len_r, i_r, pa_r;
  logic signed [6:0]   lo_r, hi_r;
  logic [VcountW-1:0]  vcount_r;
  logic [EcountW-1:0]  ecount_r;
  logic [BoundW-1:0]   vbound_r, ebound_r;
  logic [VcountW-1:0]  clr_r;
  logic [StatusW-1:0]  status_r;
  logic [LabelW-1:0]   la_r, lb_r, el_r;
  logic                ea_r, eb_r, ef_r;

  logic                range_ok;
  logic                a_new;
  logic                cap_bad;
  logic [LenW-1:0]     newlen;
  logic [LenW-1:0]     pa_inc;
  logic signed [6:0]   mid;
  logic [BoundW-1:0]   lab_inc;
  vrec_t               cur_rec;

  assign a_new    = {1'b0, a_r} >= vcount_r;
  assign range_ok = (op_r == FnAddV) ? ({1'b0, a_r} < VcountW'(MaxVertices))
                  : (!a_new && (op_r == FnRemV || {1'b0, b_r} < vcount_r));
  assign cap_bad  = ((a_r == b_r) && (7'(reca_r.len) + 7'd2 > 7'(MaxDegree)))
                 || (7'(reca_r.len) + 7'd1 > 7'(MaxDegree))
                 || (7'(recb_r.len) + 7'd1 > 7'(MaxDegree));
  assign newlen   = (op_r == FnAddE) ? len_r + LenW'(1) : len_r - LenW'(1);
  assign pa_inc   = pa_r + LenW'(1);
  assign mid      = (lo_r + hi_r) >>> 1;
  assign lab_inc  = BoundW'(lab_r) + BoundW'(1);
  assign cur_rec  = (ph_r == PH_MODA) ? reca_r : recb_r;

  always_comb begin
    vreq       = '0;
    vreq.raddr = (state_r == S_IDLE) ? in_vertex_a : b_r;
    vreq.waddr = a_r;
    vreq.wdata = reca_r;
    nreq       = '0;
    nreq.raddr = {cur_r, i_r[PosW-1:0]};
    nreq.waddr = {cur_r, i_r[PosW-1:0]};
    nreq.wdata = nrd;
    case (state_r)
      S_CLR: begin
        vreq.we    = 1'b1;
        vreq.waddr = clr_r[VidW-1:0];
        vreq.wdata = '0;
      end
      S_EXEC: begin
        if (op_r == FnAddV && range_ok && (a_new || !reca_r.present)) begin
          vreq.we    = 1'b1;
          vreq.wdata = '{present: 1'b1, len: reca_r.len, label: lab_r};
        end else if (op_r == FnRemV && range_ok) begin
          vreq.we    = 1'b1;
          vreq.wdata = '{present: 1'b0, len: '0, label: reca_r.label};
        end
      end
      S_CHK_RD:   nreq.raddr = {cur_r, pa_inc[PosW-1:0]};
      S_INS_STEP: nreq.raddr = {cur_r, 5'(i_r - LenW'(1))};
      S_INS_WR:   nreq.we = 1'b1;
      S_INS_PUT: begin
        nreq.we    = 1'b1;
        nreq.waddr = {cur_r, pa_r[PosW-1:0]};
        nreq.wdata = '{id: key_r, elabel: lab_r};
      end
      S_ERS_STEP: nreq.raddr = {cur_r, 5'(i_r + LenW'(1))};
      S_ERS_WR:   nreq.we = 1'b1;
      S_LEN_WR: begin
        vreq.we    = 1'b1;
        vreq.waddr = cur_r;
        vreq.wdata = '{present: cur_rec.present, len: newlen, label: cur_rec.label};
      end
      S_BS_STEP:  nreq.raddr = {cur_r, mid[PosW-1:0]};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLR;
      clr_r    <= '0;
      vcount_r <= '0;
      ecount_r <= '0;
      vbound_r <= '0;
      ebound_r <= '0;
      ph_r     <= PH_CHKA;
    end else begin
      case (state_r)
        S_CLR: begin
          clr_r <= clr_r + VcountW'(1);
          if (clr_r == VcountW'(MaxVertices - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            op_r     <= in_func;
            a_r      <= in_vertex_a;
            b_r      <= in_vertex_b;
            lab_r    <= in_label;
            status_r <= StDone;
            la_r     <= '0;
            lb_r     <= '0;
            el_r     <= '0;
            ea_r     <= 1'b0;
            eb_r     <= 1'b0;
            ef_r     <= 1'b0;
            state_r  <= S_RDA;
          end
        end
        S_RDA: begin
          reca_r  <= vrd;
          state_r <= S_RDB;
        end
        S_RDB: begin
          recb_r  <= vrd;
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          state_r <= S_RESP;
          if (!(op_r inside {FnAddV, FnRemV, FnAddE, FnRemE, FnLook})) begin
            status_r <= StDone;
          end else if (!range_ok) begin
            status_r <= StOor;
          end else begin
            case (op_r)
              FnAddV: begin
                if (a_new) begin
                  vcount_r <= VcountW'(a_r) + VcountW'(1);
                end else if (reca_r.present) begin
                  status_r <= StDup;
                end
                if (lab_inc > vbound_r) begin
                  vbound_r <= lab_inc;
                end
              end
              FnAddE, FnRemE: begin
                ph_r    <= PH_CHKA;
                cur_r   <= a_r;
                key_r   <= b_r;
                len_r   <= reca_r.len;
                i_r     <= '0;
                state_r <= S_SRCH_RD;
              end
              FnLook: begin
                ea_r <= reca_r.present;
                eb_r <= recb_r.present;
                la_r <= reca_r.present ? reca_r.label : '0;
                lb_r <= recb_r.present ? recb_r.label : '0;
                el_r <= '1;
                lo_r <= '0;
                if (reca_r.len < recb_r.len) begin
                  cur_r <= a_r;
                  key_r <= b_r;
                  hi_r  <= $signed({1'b0, reca_r.len}) - 7'sd1;
                end else begin
                  cur_r <= b_r;
                  key_r <= a_r;
                  hi_r  <= $signed({1'b0, recb_r.len}) - 7'sd1;
                end
                state_r <= S_BS_STEP;
              end
              default: ;
            endcase
          end
        end
        S_SRCH_RD: begin
          if (i_r < len_r) begin
            state_r <= S_SRCH_CMP;
          end else begin
            ef_r    <= 1'b0;
            state_r <= S_SDONE;
          end
        end
        S_SRCH_CMP: begin
          if (nrd.id < key_r) begin
            i_r     <= i_r + LenW'(1);
            state_r <= S_SRCH_RD;
          end else begin
            ef_r    <= (nrd.id == key_r);
            state_r <= S_SDONE;
          end
        end
        S_SDONE: begin
          ef_r <= 1'b0;
          case (ph_r)
            PH_CHKA: begin
              pa_r <= i_r;
              if (op_r == FnAddE) begin
                if (ef_r) begin
                  status_r <= StDup;
                  state_r  <= S_RESP;
                end else if (cap_bad) begin
                  status_r <= StFull;
                  state_r  <= S_RESP;
                end else begin
                  ph_r    <= PH_MODA;
                  i_r     <= len_r;
                  state_r <= S_INS_STEP;
                end
              end else if (!ef_r) begin
                status_r <= StMiss;
                state_r  <= S_RESP;
              end else if (a_r == b_r) begin
                state_r <= S_CHK_RD;
              end else begin
                ph_r    <= PH_CHKB;
                cur_r   <= b_r;
                key_r   <= a_r;
                len_r   <= recb_r.len;
                i_r     <= '0;
                state_r <= S_SRCH_RD;
              end
            end
            PH_CHKB: begin
              if (ef_r) begin
                ph_r    <= PH_MODA;
                cur_r   <= a_r;
                key_r   <= b_r;
                len_r   <= reca_r.len;
                i_r     <= pa_r;
                state_r <= S_ERS_STEP;
              end else begin
                status_r <= StMiss;
                state_r  <= S_RESP;
              end
            end
            default: begin
              pa_r <= i_r;
              if (op_r == FnAddE) begin
                i_r     <= len_r;
                state_r <= S_INS_STEP;
              end else begin
                state_r <= S_ERS_STEP;
              end
            end
          endcase
        end
        S_CHK_RD: begin
          if (pa_inc < len_r) begin
            state_r <= S_CHK_CMP;
          end else begin
            status_r <= StMiss;
            state_r  <= S_RESP;
          end
        end
        S_CHK_CMP: begin
          if (nrd.id == a_r) begin
            ph_r    <= PH_MODA;
            i_r     <= pa_r;
            state_r <= S_ERS_STEP;
          end else begin
            status_r <= StMiss;
            state_r  <= S_RESP;
          end
        end
        S_INS_STEP: begin
          state_r <= (i_r > pa_r) ? S_INS_WR : S_INS_PUT;
        end
        S_INS_WR: begin
          i_r     <= i_r - LenW'(1);
          state_r <= S_INS_STEP;
        end
        S_INS_PUT: begin
          state_r <= S_LEN_WR;
        end
        S_ERS_STEP: begin
          state_r <= (i_r + LenW'(1) < len_r) ? S_ERS_WR : S_LEN_WR;
        end
        S_ERS_WR: begin
          i_r     <= i_r + LenW'(1);
          state_r <= S_ERS_STEP;
        end
        S_LEN_WR: begin
          if (cur_r == a_r) begin
            reca_r.len <= newlen;
          end
          if (cur_r == b_r) begin
            recb_r.len <= newlen;
          end
          if (ph_r == PH_MODA) begin
            ph_r    <= PH_MODB;
            cur_r   <= b_r;
            key_r   <= a_r;
            len_r   <= (a_r == b_r) ? newlen : recb_r.len;
            i_r     <= '0;
            state_r <= S_SRCH_RD;
          end else begin
            if (op_r == FnAddE) begin
              ecount_r <= ecount_r + EcountW'(1);
              if (lab_inc > ebound_r) begin
                ebound_r <= lab_inc;
              end
            end else begin
              ecount_r <= ecount_r - EcountW'(1);
            end
            state_r <= S_RESP;
          end
        end
        S_BS_STEP: begin
          state_r <= (lo_r <= hi_r) ? S_BS_CMP : S_RESP;
          hi_r    <= (lo_r <= hi_r) ? hi_r : hi_r;
          lo_r    <= lo_r;
          i_r     <= LenW'(mid);
        end
        S_BS_CMP: begin
          if (nrd.id < key_r) begin
            lo_r    <= $signed({1'b0, i_r}) + 7'sd1;
            state_r <= S_BS_STEP;
          end else if (nrd.id > key_r) begin
            hi_r    <= $signed({1'b0, i_r}) - 7'sd1;
            state_r <= S_BS_STEP;
          end else begin
            el_r    <= nrd.elabel;
            ef_r    <= 1'b1;
            state_r <= S_RESP;
          end
        end
        S_RESP: begin
          if (res_take) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign res_valid = (state_r == S_RESP);

  always_comb begin
    res.status             = status_r;
    res.label_a            = la_r;
    res.a_exists           = ea_r;
    res.label_b            = lb_r;
    res.b_exists           = eb_r;
    res.edge_label         = el_r;
    res.edge_found         = (op_r == FnLook) && ef_r;
    res.edge_total         = ecount_r;
    res.vertex_total       = vcount_r;
    res.vertex_label_bound = vbound_r;
    res.edge_label_bound   = ebound_r;
  end

endmodule

// File: rtl/labeled_graph_sorted_adjacency_store_top.sv
// Top level of the labeled graph store: memories, sequencer and result register.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall    func, vertex_a, vertex_b, label
//   out_     output     out_valid / out_stall  status, labels, flags, totals, bounds
//
// One item at a time. Vertex operations, unused selectors and out-of-range items do no
// list work; a lookup binary-searches the shorter adjacency list. Edge operations scan
// list entries and shift entries in the neighbour memory, which has a single read and a
// single write port, up to a full list for add edge and for remove edge.
// After reset a clearing pass over all 1024 vertex memory entries holds in_stall high.
// A finished beat waits in the output register while the next item is taken.
module labeled_graph_sorted_adjacency_store_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [lgsa_pkg::FuncW-1:0]     in_func,
  input  logic [lgsa_pkg::VidW-1:0]      in_vertex_a,
  input  logic [lgsa_pkg::VidW-1:0]      in_vertex_b,
  input  logic [lgsa_pkg::LabelW-1:0]    in_label,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [lgsa_pkg::StatusW-1:0]   out_status,
  output logic [lgsa_pkg::LabelW-1:0]    out_label_a,
  output logic                           out_a_exists,
  output logic [lgsa_pkg::LabelW-1:0]    out_label_b,
  output logic                           out_b_exists,
  output logic [lgsa_pkg::LabelW-1:0]    out_edge_label,
  output logic                           out_edge_found,
  output logic [lgsa_pkg::EcountW-1:0]   out_edge_total,
  output logic [lgsa_pkg::VcountW-1:0]   out_vertex_total,
  output logic [lgsa_pkg::BoundW-1:0]    out_vertex_label_bound,
  output logic [lgsa_pkg::BoundW-1:0]    out_edge_label_bound
);
  import lgsa_pkg::*;

  vreq_t   vreq;
  vrec_t   vrd;
  nreq_t   nreq;
  nrec_t   nrd;
  logic    res_valid;
  logic    res_take;
  result_t res;
  result_t out_r;
  logic    out_valid_r;

  lgsa_ram #(.WIDTH($bits(vrec_t)), .DEPTH(MaxVertices)) u_vram (
    .clk   (clk),
    .we    (vreq.we),
    .waddr (vreq.waddr),
    .wdata (vreq.wdata),
    .raddr (vreq.raddr),
    .rdata (vrd)
  );

  lgsa_ram #(.WIDTH($bits(nrec_t)), .DEPTH(NbDepth)) u_nram (
    .clk   (clk),
    .we    (nreq.we),
    .waddr (nreq.waddr),
    .wdata (nreq.wdata),
    .raddr (nreq.raddr),
    .rdata (nrd)
  );

  lgsa_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_func     (in_func),
    .in_vertex_a (in_vertex_a),
    .in_vertex_b (in_vertex_b),
    .in_label    (in_label),
    .vreq        (vreq),
    .vrd         (vrd),
    .nreq        (nreq),
    .nrd         (nrd),
    .res_valid   (res_valid),
    .res_take    (res_take),
    .res         (res)
  );

  assign res_take = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= res_valid;
      if (res_valid) begin
        out_r <= res;
      end
    end
  end

  assign out_valid              = out_valid_r;
  assign out_status             = out_r.status;
  assign out_label_a            = out_r.label_a;
  assign out_a_exists           = out_r.a_exists;
  assign out_label_b            = out_r.label_b;
  assign out_b_exists           = out_r.b_exists;
  assign out_edge_label         = out_r.edge_label;
  assign out_edge_found         = out_r.edge_found;
  assign out_edge_total         = out_r.edge_total;
  assign out_vertex_total       = out_r.vertex_total;
  assign out_vertex_label_bound = out_r.vertex_label_bound;
  assign out_edge_label_bound   = out_r.edge_label_bound;

endmodule
